/* rtl/brl_pkg.sv */
// Shared constants and helper functions for the Bresenham line raster core.
// No dependencies; every other file of the core refers to it by scoped names.
package brl_pkg;

    // Operation codes carried by the op field of an input word.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Configuration register indexes.
    localparam int  CFG_IDX_BITS   = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_BASE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_PITCH  = 1'b1;

    // Fixed field widths.
    localparam int BASE_BITS  = 24;
    localparam int PITCH_BITS = 13;
    localparam int COLOR_BITS = 8;
    localparam int CFG_DATA_BITS = 24;
    localparam logic [PITCH_BITS-1:0] PITCH_RESET = 13'd640;

    // Command queue between the front and the back.
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_BITS  = 2;
    localparam int Q_CNT_BITS  = 3;

    // Width of one decoded command word: op, active, address, major, minor,
    // error term, axis and sign flags, and colour.
    function automatic int cmd_bits(input int coord_bits, input int addr_bits);
        return 2 + addr_bits + 2 * coord_bits + (coord_bits + 2) + 3 + COLOR_BITS;
    endfunction

endpackage

/* rtl/brl_front.sv */
// Front end of the line raster core: accepts input words, works out deltas,
// signs, major axis, initial error and start address, and pushes commands.
// Depends on brl_pkg.
module brl_front #(
    parameter int COORD_BITS = 12,
    parameter int ADDR_BITS  = 25,
    parameter int CMD_BITS   = brl_pkg::cmd_bits(12, 25)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_op,
    input  logic [COORD_BITS-1:0]            i_start_x,
    input  logic [COORD_BITS-1:0]            i_start_y,
    input  logic [COORD_BITS-1:0]            i_end_x,
    input  logic [COORD_BITS-1:0]            i_end_y,
    input  logic [brl_pkg::COLOR_BITS-1:0]   i_draw_color,
    input  logic [brl_pkg::BASE_BITS-1:0]    i_frame_base,
    input  logic [brl_pkg::PITCH_BITS-1:0]   i_row_pitch,
    input  logic                             i_q_full,
    output logic                             o_push,
    output logic [CMD_BITS-1:0]              o_cmd
);

    localparam int ERR_BITS  = COORD_BITS + 2;
    localparam int PROD_BITS = COORD_BITS + brl_pkg::PITCH_BITS;

    typedef struct packed {
        logic                           op;
        logic                           active;
        logic [ADDR_BITS-1:0]           addr;
        logic [COORD_BITS-1:0]          major;
        logic [COORD_BITS-1:0]          minor;
        logic signed [ERR_BITS-1:0]     err;
        logic                           x_is_major;
        logic                           x_neg;
        logic                           y_neg;
        logic [brl_pkg::COLOR_BITS-1:0] color;
    } t_cmd;

    // Stage register holding the first half of the load set-up.
    logic                            r_s1_valid;
    logic                            r_op;
    logic                            r_x_neg;
    logic                            r_y_neg;
    logic [COORD_BITS-1:0]           r_adx;
    logic [COORD_BITS-1:0]           r_ady;
    logic [COORD_BITS-1:0]           r_sx;
    logic [PROD_BITS-1:0]            r_prod;
    logic [brl_pkg::COLOR_BITS-1:0]  r_color;

    logic n_x_neg;
    logic n_y_neg;
    logic accept;
    logic advance;
    t_cmd cmd;

    assign o_in_stall = r_s1_valid & i_q_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign advance    = r_s1_valid & ~i_q_full;
    assign n_x_neg    = i_end_x < i_start_x;
    assign n_y_neg    = i_end_y < i_start_y;

    // Stage one: absolute deltas, directions and the row offset product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
        if (accept) begin
            r_op    <= i_op;
            r_x_neg <= n_x_neg;
            r_y_neg <= n_y_neg;
            r_adx   <= n_x_neg ? i_start_x - i_end_x : i_end_x - i_start_x;
            r_ady   <= n_y_neg ? i_start_y - i_end_y : i_end_y - i_start_y;
            r_sx    <= i_start_x;
            r_prod  <= PROD_BITS'(i_start_y) * PROD_BITS'(i_row_pitch);
            r_color <= i_draw_color;
        end
    end

    // Stage two: pick the major axis, set the error term and the start address.
    always_comb begin
        cmd.op         = r_op;
        cmd.x_is_major = r_adx > r_ady;
        cmd.major      = cmd.x_is_major ? r_adx : r_ady;
        cmd.minor      = cmd.x_is_major ? r_ady : r_adx;
        cmd.err        = signed'({1'b0, cmd.minor, 1'b0}) - signed'({2'b00, cmd.major});
        cmd.active     = cmd.major != '0;
        cmd.addr       = ADDR_BITS'(i_frame_base) + ADDR_BITS'(r_prod) + ADDR_BITS'(r_sx);
        cmd.x_neg      = r_x_neg;
        cmd.y_neg      = r_y_neg;
        cmd.color      = r_color;
    end

    assign o_push = advance;
    assign o_cmd  = cmd;

endmodule

/* rtl/brl_queue.sv */
// Short command queue that decouples the set-up front end from the stepper.
// Depends on brl_pkg for its depth and pointer widths.
module brl_queue #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0]                 r_mem [brl_pkg::Q_DEPTH];
    logic [brl_pkg::Q_PTR_BITS-1:0]   r_wr_ptr;
    logic [brl_pkg::Q_PTR_BITS-1:0]   r_rd_ptr;
    logic [brl_pkg::Q_CNT_BITS-1:0]   r_count;

    logic do_pop;

    assign o_full  = r_count == brl_pkg::Q_CNT_BITS'(brl_pkg::Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop & o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage for queued words.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/brl_back.sv */
// Back end of the line raster core: holds the active line, steps it one pixel
// per step word and drives the registered pixel output. Depends on brl_pkg.
module brl_back #(
    parameter int COORD_BITS = 12,
    parameter int ADDR_BITS  = 25,
    parameter int CMD_BITS   = brl_pkg::cmd_bits(12, 25)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [brl_pkg::PITCH_BITS-1:0]   i_row_pitch,
    input  logic                             i_q_valid,
    input  logic [CMD_BITS-1:0]              i_cmd,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ADDR_BITS-1:0]             o_pixel_addr,
    output logic [brl_pkg::COLOR_BITS-1:0]   o_pixel_color,
    output logic                             o_last_pixel
);

    localparam int ERR_BITS = COORD_BITS + 2;

    typedef struct packed {
        logic                           op;
        logic                           active;
        logic [ADDR_BITS-1:0]           addr;
        logic [COORD_BITS-1:0]          major;
        logic [COORD_BITS-1:0]          minor;
        logic signed [ERR_BITS-1:0]     err;
        logic                           x_is_major;
        logic                           x_neg;
        logic                           y_neg;
        logic [brl_pkg::COLOR_BITS-1:0] color;
    } t_cmd;

    // Line state.
    logic                            r_active;
    logic [ADDR_BITS-1:0]            r_addr;
    logic signed [ERR_BITS-1:0]      r_err;
    logic [COORD_BITS-1:0]           r_left;
    logic [COORD_BITS-1:0]           r_major;
    logic [COORD_BITS-1:0]           r_minor;
    logic                            r_x_is_major;
    logic                            r_x_neg;
    logic                            r_y_neg;
    logic [brl_pkg::COLOR_BITS-1:0]  r_color;

    // Output register.
    logic                            r_out_valid;
    logic [ADDR_BITS-1:0]            r_out_addr;
    logic [brl_pkg::COLOR_BITS-1:0]  r_out_color;
    logic                            r_out_last;

    t_cmd                        cmd;
    logic                        out_free;
    logic                        is_load;
    logic                        do_step;
    logic [ADDR_BITS-1:0]        pitch_ext;
    logic [ADDR_BITS-1:0]        d_major;
    logic [ADDR_BITS-1:0]        d_minor;
    logic                        minor_move;
    logic [ADDR_BITS-1:0]        n_addr;
    logic signed [ERR_BITS-1:0]  n_err;
    logic [COORD_BITS-1:0]       n_left;

    assign cmd      = i_cmd;
    assign is_load  = cmd.op == brl_pkg::OP_LOAD;
    assign out_free = ~r_out_valid | ~i_out_stall;
    assign o_pop    = i_q_valid & (is_load | ~r_active | out_free);
    assign do_step  = o_pop & ~is_load & r_active;

    // Signed address increments along the major and minor axes.
    always_comb begin
        pitch_ext = ADDR_BITS'(i_row_pitch);
        if (r_x_is_major) begin
            d_major = r_x_neg ? '1 : ADDR_BITS'(1);
            d_minor = r_y_neg ? (~pitch_ext + 1'b1) : pitch_ext;
        end else begin
            d_major = r_y_neg ? (~pitch_ext + 1'b1) : pitch_ext;
            d_minor = r_x_neg ? '1 : ADDR_BITS'(1);
        end
    end

    // One Bresenham step: error update and address advance.
    always_comb begin
        minor_move = ~r_err[ERR_BITS-1];
        n_err      = r_err + signed'({1'b0, r_minor, 1'b0})
                     - (minor_move ? signed'({1'b0, r_major, 1'b0}) : '0);
        n_addr     = r_addr + d_major + (minor_move ? d_minor : '0);
        n_left     = r_left - 1'b1;
    end

    // Line state update on load and step words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_pop && is_load) begin
            r_active <= cmd.active;
        end else if (do_step && r_left == COORD_BITS'(1)) begin
            r_active <= 1'b0;
        end
        if (o_pop && is_load) begin
            r_addr       <= cmd.addr;
            r_err        <= cmd.err;
            r_left       <= cmd.major;
            r_major      <= cmd.major;
            r_minor      <= cmd.minor;
            r_x_is_major <= cmd.x_is_major;
            r_x_neg      <= cmd.x_neg;
            r_y_neg      <= cmd.y_neg;
            r_color      <= cmd.color;
        end else if (do_step) begin
            r_addr <= n_addr;
            r_err  <= n_err;
            r_left <= n_left;
        end
    end

    // Pixel output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (do_step) begin
            r_out_addr  <= r_addr;
            r_out_color <= r_color;
            r_out_last  <= r_left == COORD_BITS'(1);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_addr  = r_out_addr;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

endmodule

/* rtl/bresenham_line_raster_core.sv */
// Bresenham line raster core: one pixel write per step word on an active line.
// A step word passes through the set-up stage register, the command queue and
// the stepper output register on its way to the pixel outputs.
// Throughput: one word per cycle while the pixel output is not stalled, set by the stepper update.
// Reset clears the queue, the active line and the output; frame_base resets
// to 0 and row_pitch to 640. Depends on brl_pkg, brl_front, brl_queue, brl_back.
module bresenham_line_raster_core #(
    parameter int COORD_BITS = 12,
    parameter int ADDR_BITS  = 25
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic [COORD_BITS-1:0]               i_start_x,
    input  logic [COORD_BITS-1:0]               i_start_y,
    input  logic [COORD_BITS-1:0]               i_end_x,
    input  logic [COORD_BITS-1:0]               i_end_y,
    input  logic [brl_pkg::COLOR_BITS-1:0]      i_draw_color,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ADDR_BITS-1:0]                o_pixel_addr,
    output logic [brl_pkg::COLOR_BITS-1:0]      o_pixel_color,
    output logic                                o_last_pixel,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [brl_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [brl_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int CMD_BITS = brl_pkg::cmd_bits(COORD_BITS, ADDR_BITS);

    logic [brl_pkg::BASE_BITS-1:0]  r_frame_base;
    logic [brl_pkg::PITCH_BITS-1:0] r_row_pitch;

    logic                q_full;
    logic                q_push;
    logic [CMD_BITS-1:0] q_in;
    logic                q_pop;
    logic                q_valid;
    logic [CMD_BITS-1:0] q_out;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= '0;
            r_row_pitch  <= brl_pkg::PITCH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                brl_pkg::REG_FRAME_BASE: r_frame_base <= i_cfg_data[brl_pkg::BASE_BITS-1:0];
                brl_pkg::REG_ROW_PITCH:  r_row_pitch  <= i_cfg_data[brl_pkg::PITCH_BITS-1:0];
                default: ;
            endcase
        end
    end

    brl_front #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS),
        .CMD_BITS   (CMD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_draw_color (i_draw_color),
        .i_frame_base (r_frame_base),
        .i_row_pitch  (r_row_pitch),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_cmd        (q_in)
    );

    brl_queue #(
        .WIDTH (CMD_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    brl_back #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS),
        .CMD_BITS   (CMD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_row_pitch   (r_row_pitch),
        .i_q_valid     (q_valid),
        .i_cmd         (q_out),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_addr  (o_pixel_addr),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

endmodule
